[rtl/core/texture_vram_row_packer_core_defines.svh]
// ----------------------------------------------------------------------------
// Texture VRAM row packer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TEXTURE_VRAM_ROW_PACKER_CORE_DEFINES_SVH
`define TEXTURE_VRAM_ROW_PACKER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TVRP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TVRP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/tvrp_pkg.sv]
// ----------------------------------------------------------------------------
// Texture VRAM row packer package
// Field widths, profile constants, codes and the rounding and edge alignment functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tvrp_pkg;

    localparam int ROWS_DEFAULT = 256;

    localparam int EDGE_W   = 9;
    localparam int REQ_W    = 10;
    localparam int WROUND_W = 11;
    localparam int XY_W     = 8;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_PACK_ENABLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_MODE  = 1'b1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam logic [EDGE_W-1:0] EDGE_FLAT = 9'h0c0;
    localparam logic [EDGE_W-1:0] EDGE_LOW  = 9'h0e0;
    localparam logic [EDGE_W-1:0] EDGE_HIGH = 9'h100;
    localparam int                LOW_ROWS  = 'h80;

    localparam logic [WROUND_W-1:0] MIN_WIDTH = 11'd8;

    typedef struct packed {
        logic              ok;
        logic [EDGE_W-1:0] value;
    } align_t;

    // Width rounded up to at least the minimum and to an even value.
    function automatic logic [WROUND_W-1:0] round_width(input logic [REQ_W-1:0] req);
        logic [WROUND_W-1:0] w;
        w = {1'b0, req};
        if (w < MIN_WIDTH) begin
            w = MIN_WIDTH;
        end
        if (w[0]) begin
            w = w + 11'd1;
        end
        return w;
    endfunction

    // Height rounded up to a multiple of eight rows.
    function automatic logic [WROUND_W-1:0] round_height(input logic [REQ_W-1:0] req);
        logic [WROUND_W-1:0] h;
        h = {1'b0, req} + 11'd7;
        return {h[WROUND_W-1:3], 3'b000};
    endfunction

    // Largest value at or below the edge, in steps of eight, whose bits under
    // the width mask are all clear. It fails when the low three bits of the
    // edge collide with the mask, since steps of eight never change them.
    function automatic align_t align_edge(input logic [EDGE_W-1:0] edge_v,
                                          input logic [WROUND_W-1:0] w);
        logic [WROUND_W-1:0] m;
        logic [5:0]          e_hi;
        logic [5:0]          m_hi;
        logic [5:0]          hit;
        logic [5:0]          below;
        logic [5:0]          v;
        align_t              res;
        m     = w - 11'd1;
        e_hi  = edge_v[8:3];
        m_hi  = m[8:3];
        hit   = e_hi & m_hi;
        v     = e_hi;
        below = 6'd0;
        for (int p = 0; p < 6; p++) begin
            if (hit[p]) begin
                below = (6'd1 << p) - 6'd1;
                v     = (e_hi & ~((below << 1) | 6'd1)) | (below & ~m_hi);
            end
        end
        res.ok    = ((edge_v[2:0] & m[2:0]) == 3'd0);
        res.value = {v, edge_v[2:0]};
        return res;
    endfunction

endpackage

`default_nettype wire

[rtl/core/tvrp_if.sv]
// ----------------------------------------------------------------------------
// Texture VRAM row packer channels
// Valid/ready interfaces for the request and the response channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tvrp_req_if;
    import tvrp_pkg::*;

    logic             valid;
    logic             ready;
    logic             opcode;
    logic [REQ_W-1:0] req_width;
    logic [REQ_W-1:0] req_height;

    modport source (output valid, output opcode, output req_width, output req_height,
                    input ready);
    modport sink   (input valid, input opcode, input req_width, input req_height,
                    output ready);
endinterface

interface tvrp_rsp_if;
    import tvrp_pkg::*;

    logic            valid;
    logic            ready;
    logic            ok;
    logic [XY_W-1:0] x_pos;
    logic [XY_W-1:0] y_row;

    modport source (output valid, output ok, output x_pos, output y_row, input ready);
    modport sink   (input valid, input ok, input x_pos, input y_row, output ready);
endinterface

`default_nettype wire

[rtl/core/texture_vram_row_packer_core.sv]
// ----------------------------------------------------------------------------
// Texture VRAM row packer core
// Skyline rectangle allocator over a per-row free-edge memory.
// ----------------------------------------------------------------------------
// Usage: a request transfer on req carries an opcode and a width and height.
// Every request produces exactly one response transfer on rsp with ok, x_pos
// and y_row. Allocation runs a forward pass that stores per-block prefix
// minima of the edges, a backward pass that forms suffix minima and scores
// every window, and a write pass over the rows of the winning window.
// Each allocation pass visits the edge memory once through its single read port.
// A clear makes one edge memory write per row. A failed allocation that needs
// no scan goes straight to its response. One request is worked on at a time.
// After reset the block loads 0xc0 into every row and holds req.ready low
// meanwhile; configuration writes are taken throughout. The response sits
// in an output register, so a new request is accepted while the previous
// response waits; a finished item waits only when that register is still
// full. Configuration is written through cfg_we, cfg_index and cfg_wdata
// and takes effect at the next clock edge.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "texture_vram_row_packer_core_defines.svh"

module texture_vram_row_packer_core #(
    parameter int ROWS = tvrp_pkg::ROWS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    tvrp_req_if.sink                        req,
    tvrp_rsp_if.source                      rsp,
    input  logic                            cfg_we,
    input  logic [tvrp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tvrp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import tvrp_pkg::*;

    localparam int IDX_W = $clog2(ROWS);
    localparam logic [IDX_W-1:0]    LAST_ROW = IDX_W'(ROWS - 1);
    localparam logic [IDX_W:0]      ROWS_EXT = (IDX_W + 1)'(ROWS);
    localparam logic [WROUND_W-1:0] ROWS_LIM = WROUND_W'(ROWS);

    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_CLEAR  = 3'd2;
    localparam logic [2:0] ST_FWD    = 3'd3;
    localparam logic [2:0] ST_BWD    = 3'd4;
    localparam logic [2:0] ST_EVAL   = 3'd5;
    localparam logic [2:0] ST_COMMIT = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    logic [EDGE_W-1:0] edge_mem [ROWS];
    logic [EDGE_W-1:0] pmin_mem [ROWS];

    logic [2:0]          state_reg,        state_next;
    logic [IDX_W-1:0]    cnt_reg,          cnt_next;
    logic [IDX_W-1:0]    blk_reg,          blk_next;
    logic                pack_en_reg,      pack_en_next;
    logic                level_mode_reg,   level_mode_next;
    logic                found_reg,        found_next;
    logic                rd_vld_reg,       rd_vld_next;
    logic                rd_bwd_reg,       rd_bwd_next;
    logic                rsp_valid_reg,    rsp_valid_next;
    logic [WROUND_W-1:0] w_reg,            w_next;
    logic [IDX_W-1:0]    h_reg,            h_next;
    logic [IDX_W-1:0]    sel_row_reg,      sel_row_next;
    logic [EDGE_W-1:0]   sel_edge_reg,     sel_edge_next;
    logic [EDGE_W-1:0]   best_aligned_reg, best_aligned_next;
    logic [EDGE_W-1:0]   run_min_reg,      run_min_next;
    logic                res_ok_reg,       res_ok_next;
    logic [XY_W-1:0]     res_x_reg,        res_x_next;
    logic [XY_W-1:0]     res_y_reg,        res_y_next;
    logic                rsp_ok_reg,       rsp_ok_next;
    logic [XY_W-1:0]     rsp_x_reg,        rsp_x_next;
    logic [XY_W-1:0]     rsp_y_reg,        rsp_y_next;
    logic [IDX_W-1:0]    rd_idx_reg,       rd_idx_next;
    logic                rd_bound_reg,     rd_bound_next;
    logic                rd_inrange_reg,   rd_inrange_next;
    logic [EDGE_W-1:0]   edge_rdata_reg;
    logic [EDGE_W-1:0]   pmin_rdata_reg;

    logic                edge_we;
    logic [IDX_W-1:0]    edge_waddr;
    logic [EDGE_W-1:0]   edge_wdata;
    logic                pmin_we;
    logic [IDX_W-1:0]    pmin_raddr;
    logic [IDX_W:0]      win_end;
    logic                in_range;
    logic [IDX_W-1:0]    h_last;
    logic [EDGE_W-1:0]   blk_min;
    logic [EDGE_W-1:0]   win_min;
    logic [EDGE_W-1:0]   place_x;
    logic [EDGE_W-1:0]   profile;
    logic                low_row;
    logic                cand;
    logic                take;
    logic [WROUND_W-1:0] w_round;
    logic [WROUND_W-1:0] h_round;
    align_t              al;

    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid = rsp_valid_reg;
    assign rsp.ok    = rsp_ok_reg;
    assign rsp.x_pos = rsp_x_reg;
    assign rsp.y_row = rsp_y_reg;

    assign w_round  = round_width(req.req_width);
    assign h_round  = round_height(req.req_height);
    assign h_last   = h_reg - IDX_W'(1);
    assign win_end  = {1'b0, cnt_reg} + {1'b0, h_reg};
    assign in_range = (win_end <= ROWS_EXT);
    assign pmin_raddr = in_range ? IDX_W'(win_end - (IDX_W + 1)'(1)) : '0;

    assign blk_min = (rd_bound_reg || (edge_rdata_reg < run_min_reg)) ?
                     edge_rdata_reg : run_min_reg;
    assign win_min = (pmin_rdata_reg < blk_min) ? pmin_rdata_reg : blk_min;
    assign al      = align_edge(edge_rdata_reg, w_reg);
    assign cand    = rd_vld_reg && rd_bwd_reg && rd_inrange_reg && al.ok &&
                     (w_reg[WROUND_W-1:EDGE_W] == '0) && (al.value >= w_reg[EDGE_W-1:0]) &&
                     (win_min >= al.value);
    assign take    = cand && (!found_reg || (edge_rdata_reg >= sel_edge_reg));
    assign pmin_we = rd_vld_reg && !rd_bwd_reg;
    assign place_x = best_aligned_reg - w_reg[EDGE_W-1:0];

    assign low_row = (32'(cnt_reg) < 32'(LOW_ROWS));
    assign profile = ((state_reg == ST_CLEAR) && level_mode_reg) ?
                     (low_row ? EDGE_LOW : EDGE_HIGH) : EDGE_FLAT;

    always_comb
    begin
        edge_we    = 1'b0;
        edge_waddr = cnt_reg;
        edge_wdata = profile;
        case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                edge_we = 1'b1;
            end
            ST_COMMIT:
            begin
                edge_we    = 1'b1;
                edge_waddr = sel_row_reg + cnt_reg;
                edge_wdata = place_x;
            end
            default:
            begin
                edge_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        blk_next          = blk_reg;
        pack_en_next      = pack_en_reg;
        level_mode_next   = level_mode_reg;
        found_next        = found_reg;
        w_next            = w_reg;
        h_next            = h_reg;
        sel_row_next      = sel_row_reg;
        sel_edge_next     = sel_edge_reg;
        best_aligned_next = best_aligned_reg;
        run_min_next      = rd_vld_reg ? blk_min : run_min_reg;
        res_ok_next       = res_ok_reg;
        res_x_next        = res_x_reg;
        res_y_next        = res_y_reg;
        rsp_valid_next    = rsp_valid_reg && !rsp.ready;
        rsp_ok_next       = rsp_ok_reg;
        rsp_x_next        = rsp_x_reg;
        rsp_y_next        = rsp_y_reg;
        rd_vld_next       = (state_reg == ST_FWD) || (state_reg == ST_BWD);
        rd_bwd_next       = (state_reg == ST_BWD);
        rd_idx_next       = cnt_reg;
        rd_inrange_next   = in_range;
        rd_bound_next     = (state_reg == ST_FWD) ? (blk_reg == '0) :
                            ((blk_reg == h_last) || (cnt_reg == LAST_ROW));

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_PACK_ENABLE: pack_en_next    = cfg_wdata[0];
                CFG_LEVEL_MODE:  level_mode_next = cfg_wdata[0];
                default:         pack_en_next    = pack_en_reg;
            endcase
        end

        if (take)
        begin
            found_next        = 1'b1;
            sel_row_next      = rd_idx_reg;
            sel_edge_next     = edge_rdata_reg;
            best_aligned_next = al.value;
        end

        case (state_reg)
            ST_INIT:
            begin
                cnt_next = cnt_reg + IDX_W'(1);
                if (cnt_reg == LAST_ROW)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    w_next      = w_round;
                    h_next      = IDX_W'(h_round);
                    found_next  = 1'b0;
                    cnt_next    = '0;
                    blk_next    = '0;
                    res_ok_next = 1'b0;
                    res_x_next  = '0;
                    res_y_next  = '0;
                    if (req.opcode == OP_CLEAR)
                    begin
                        pack_en_next = 1'b1;
                        state_next   = ST_CLEAR;
                    end
                    else if (!pack_en_reg || (h_round == '0) || (h_round >= ROWS_LIM))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_FWD;
                    end
                end
            end
            ST_CLEAR:
            begin
                cnt_next = cnt_reg + IDX_W'(1);
                if (cnt_reg == LAST_ROW)
                begin
                    res_ok_next = 1'b1;
                    state_next  = ST_DONE;
                end
            end
            ST_FWD:
            begin
                if (cnt_reg == LAST_ROW)
                begin
                    state_next = ST_BWD;
                end
                else
                begin
                    cnt_next = cnt_reg + IDX_W'(1);
                    blk_next = (blk_reg == h_last) ? '0 : blk_reg + IDX_W'(1);
                end
            end
            ST_BWD:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_EVAL;
                end
                else
                begin
                    cnt_next = cnt_reg - IDX_W'(1);
                    blk_next = (blk_reg == '0) ? h_last : blk_reg - IDX_W'(1);
                end
            end
            ST_EVAL:
            begin
                cnt_next   = '0;
                state_next = found_next ? ST_COMMIT : ST_DONE;
            end
            ST_COMMIT:
            begin
                cnt_next = cnt_reg + IDX_W'(1);
                if (cnt_reg == h_last)
                begin
                    res_ok_next = 1'b1;
                    res_x_next  = place_x[XY_W-1:0];
                    res_y_next  = XY_W'(sel_row_reg);
                    state_next  = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_ok_next    = res_ok_reg;
                    rsp_x_next     = res_x_reg;
                    rsp_y_next     = res_y_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            cnt_reg        <= '0;
            blk_reg        <= '0;
            pack_en_reg    <= 1'b1;
            level_mode_reg <= 1'b0;
            found_reg      <= 1'b0;
            rd_vld_reg     <= 1'b0;
            rd_bwd_reg     <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            blk_reg        <= blk_next;
            pack_en_reg    <= pack_en_next;
            level_mode_reg <= level_mode_next;
            found_reg      <= found_next;
            rd_vld_reg     <= rd_vld_next;
            rd_bwd_reg     <= rd_bwd_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg            <= w_next;
        h_reg            <= h_next;
        sel_row_reg      <= sel_row_next;
        sel_edge_reg     <= sel_edge_next;
        best_aligned_reg <= best_aligned_next;
        run_min_reg      <= run_min_next;
        res_ok_reg       <= res_ok_next;
        res_x_reg        <= res_x_next;
        res_y_reg        <= res_y_next;
        rsp_ok_reg       <= rsp_ok_next;
        rsp_x_reg        <= rsp_x_next;
        rsp_y_reg        <= rsp_y_next;
        rd_idx_reg       <= rd_idx_next;
        rd_bound_reg     <= rd_bound_next;
        rd_inrange_reg   <= rd_inrange_next;
    end

    always_ff @(posedge clk)
    begin
        if (edge_we)
        begin
            edge_mem[edge_waddr] <= edge_wdata;
        end
        edge_rdata_reg <= edge_mem[cnt_reg];
    end

    always_ff @(posedge clk)
    begin
        if (pmin_we)
        begin
            pmin_mem[rd_idx_reg] <= blk_min;
        end
        pmin_rdata_reg <= pmin_mem[pmin_raddr];
    end

    `TVRP_ASSERT_SAME(a_no_edge_write_in_scan,
        (state_reg == ST_FWD) || (state_reg == ST_BWD) || (state_reg == ST_EVAL),
        !edge_we, "Edge memory written during a scan pass.")

    `TVRP_ASSERT_SAME(a_commit_in_window,
        edge_we && (state_reg == ST_COMMIT),
        (edge_waddr >= sel_row_reg) && ((edge_waddr - sel_row_reg) < h_reg),
        "Commit write falls outside the winning window.")

    `TVRP_ASSERT_SAME(a_best_fits_width,
        found_reg,
        (w_reg[WROUND_W-1:EDGE_W] == '0) && (best_aligned_reg >= w_reg[EDGE_W-1:0]),
        "Winning aligned edge is below the rounded width.")

    `TVRP_ASSERT_NEXT(a_done_delivers,
        (state_reg == ST_DONE) && (!rsp_valid_reg || rsp.ready),
        rsp_valid_reg && (state_reg == ST_IDLE),
        "Finished item did not reach the response register.")

endmodule

`default_nettype wire

[dv/tb_texture_vram_row_packer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Texture VRAM row packer core testbench
// Sends allocate and clear requests through the request channel and checks
// every response against a local skyline predictor that tracks the free edge
// of each row. The test runs a directed part for height and width limits,
// alignment, the disabled state and the level profile. It then runs random
// phases under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------

module tb_texture_vram_row_packer_core;
    import tvrp_pkg::*;

    localparam int ROWS        = ROWS_DEFAULT;
    localparam int CYCLE_LIMIT = 6_000_000;
    localparam int TAIL_CYCLES = 3 * ROWS + 8;

    typedef struct packed {
        logic            ok;
        logic [XY_W-1:0] x_pos;
        logic [XY_W-1:0] y_row;
    } placement_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    tvrp_req_if req_bus ();
    tvrp_rsp_if rsp_bus ();

    texture_vram_row_packer_core #(
        .ROWS(ROWS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_bus),
        .rsp      (rsp_bus),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    logic [EDGE_W-1:0] row_edge_model [ROWS];
    logic              model_enable;
    logic              model_level_mode;

    placement_t expected_placements [$];
    int         mismatches     = 0;
    int         cycle_count    = 0;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("texture_vram_row_packer_core verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_bus.ready <= 1'b0;
        end
        else
        begin
            rsp_bus.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        placement_t exp_p;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (expected_placements.size() == 0)
            begin
                $error("response transfer with no request pending: ok=%0b x_pos=%0d y_row=%0d",
                       rsp_bus.ok, rsp_bus.x_pos, rsp_bus.y_row);
                mismatches++;
            end
            else
            begin
                exp_p = expected_placements.pop_front();
                if (rsp_bus.ok !== exp_p.ok)
                begin
                    $error("ok: expected %0b, actual %0b", exp_p.ok, rsp_bus.ok);
                    mismatches++;
                end
                if (rsp_bus.x_pos !== exp_p.x_pos)
                begin
                    $error("x_pos: expected %0d, actual %0d", exp_p.x_pos, rsp_bus.x_pos);
                    mismatches++;
                end
                if (rsp_bus.y_row !== exp_p.y_row)
                begin
                    $error("y_row: expected %0d, actual %0d", exp_p.y_row, rsp_bus.y_row);
                    mismatches++;
                end
            end
        end
    end

    function automatic void load_level_profile();
        for (int r = 0; r < ROWS; r++)
        begin
            if (!model_level_mode)
                row_edge_model[r] = EDGE_FLAT;
            else if (r < LOW_ROWS)
                row_edge_model[r] = EDGE_LOW;
            else
                row_edge_model[r] = EDGE_HIGH;
        end
    endfunction

    // Steps the edge down by eight until no bit under the width mask is set.
    function automatic bit align_down(input int edge_v, input int width, output int aligned);
        int mask;
        aligned = edge_v;
        mask    = width - 1;
        while ((aligned & mask) != 0)
        begin
            if (aligned < 8)
                return 1'b0;
            aligned -= 8;
        end
        return 1'b1;
    endfunction

    function automatic placement_t predict_placement(input logic op,
                                                     input logic [REQ_W-1:0] req_w,
                                                     input logic [REQ_W-1:0] req_h);
        placement_t res;
        int         w;
        int         h;
        int         a;
        int         sel_row;
        int         sel_edge;
        int         best_aligned;
        bit         found;
        bit         fits;
        res          = '0;
        found        = 1'b0;
        sel_row      = 0;
        sel_edge     = 0;
        best_aligned = 0;
        if (op == OP_CLEAR)
        begin
            model_enable = 1'b1;
            load_level_profile();
            res.ok = 1'b1;
            return res;
        end
        if (!model_enable)
            return res;
        w = int'(req_w);
        if (w < 8)
            w = 8;
        if (w % 2 != 0)
            w++;
        h = int'(req_h);
        if (h % 8 != 0)
            h += 8 - (h % 8);
        if (h == 0 || h >= ROWS)
            return res;
        for (int r = 0; r + h <= ROWS; r++)
        begin
            fits = align_down(int'(row_edge_model[r]), w, a);
            if (a < w)
                fits = 1'b0;
            for (int i = 0; fits && i < h; i++)
            begin
                if (int'(row_edge_model[r + i]) < w || int'(row_edge_model[r + i]) < a)
                    fits = 1'b0;
            end
            if (fits && (!found || int'(row_edge_model[r]) > sel_edge))
            begin
                found        = 1'b1;
                sel_row      = r;
                sel_edge     = int'(row_edge_model[r]);
                best_aligned = a;
            end
        end
        if (!found)
            return res;
        for (int r = 0; r < h; r++)
            row_edge_model[sel_row + r] = EDGE_W'(best_aligned - w);
        res.ok    = 1'b1;
        res.x_pos = XY_W'(best_aligned - w);
        res.y_row = XY_W'(sel_row);
        return res;
    endfunction

    // Called right after a rising edge; leaves valid high after the transfer.
    task automatic send_request(input logic op, input logic [REQ_W-1:0] req_w,
                                input logic [REQ_W-1:0] req_h);
        int gap;
        gap = 0;
        while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid      <= 1'b1;
        req_bus.opcode     <= op;
        req_bus.req_width  <= req_w;
        req_bus.req_height <= req_h;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        expected_placements.push_back(predict_placement(op, req_w, req_h));
    endtask

    task automatic stop_requests();
        req_bus.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_for_results();
        while (expected_placements.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_PACK_ENABLE)
            model_enable = val[0];
        else
            model_level_mode = val[0];
    endtask

    task automatic settle_and_write(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
        stop_requests();
        wait_for_results();
        write_reg(idx, val);
    endtask

    task automatic test_height_and_width_limits();
        send_request(OP_ALLOC, 10'd0, 10'd0);
        send_request(OP_ALLOC, 10'd1023, 10'd1023);
        send_request(OP_ALLOC, 10'd8, 10'd256);
        send_request(OP_ALLOC, 10'd8, 10'd249);
        send_request(OP_ALLOC, 10'd0, 10'd248);
        send_request(OP_ALLOC, 10'd1023, 10'd8);
        send_request(OP_ALLOC, 10'd7, 10'd1);
    endtask

    task automatic test_alignment();
        send_request(OP_ALLOC, 10'd9, 10'd9);
        send_request(OP_ALLOC, 10'd10, 10'd16);
        send_request(OP_ALLOC, 10'd8, 10'd8);
        send_request(OP_ALLOC, 10'd64, 10'd24);
        send_request(OP_ALLOC, 10'd512, 10'd8);
        send_request(OP_CLEAR, 10'd1023, 10'd1023);
    endtask

    task automatic test_disabled();
        settle_and_write(CFG_PACK_ENABLE, 1'b0);
        send_request(OP_ALLOC, 10'd8, 10'd8);
        send_request(OP_ALLOC, 10'd1023, 10'd0);
        send_request(OP_CLEAR, 10'd0, 10'd0);
        send_request(OP_ALLOC, 10'd8, 10'd8);
    endtask

    task automatic test_level_profile();
        settle_and_write(CFG_LEVEL_MODE, 1'b1);
        send_request(OP_CLEAR, 10'd0, 10'd0);
        send_request(OP_ALLOC, 10'd256, 10'd128);
        send_request(OP_ALLOC, 10'd8, 10'd200);
        send_request(OP_ALLOC, 10'd8, 10'd8);
        send_request(OP_ALLOC, 10'd32, 10'd120);
        settle_and_write(CFG_LEVEL_MODE, 1'b0);
        send_request(OP_CLEAR, 10'd0, 10'd0);
    endtask

    task automatic send_random_item();
        int sel;
        sel = $urandom_range(99, 0);
        if (sel < 4)
            send_request(OP_CLEAR, REQ_W'($urandom), REQ_W'($urandom));
        else if (sel < 10)
            send_request(OP_ALLOC, REQ_W'($urandom_range(1023, 0)),
                         REQ_W'($urandom_range(1023, 0)));
        else if (sel < 20)
            send_request(OP_ALLOC, REQ_W'($urandom_range(300, 0)),
                         REQ_W'($urandom_range(255, 0)));
        else
            send_request(OP_ALLOC, REQ_W'($urandom_range(64, 0)),
                         REQ_W'($urandom_range(64, 0)));
    endtask

    task automatic run_random_burst(input int count, input int send_pct, input int recv_pct,
                                    input bit drain_pauses);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int n = 0; n < count; n++)
        begin
            if (drain_pauses && n % 60 == 59)
            begin
                stop_requests();
                wait_for_results();
            end
            send_random_item();
        end
    endtask

    task automatic test_random_no_idle();
        settle_and_write(CFG_PACK_ENABLE, 1'b1);
        run_random_burst(300, 0, 0, 1'b0);
    endtask

    task automatic test_random_sender_idle();
        settle_and_write(CFG_LEVEL_MODE, 1'b1);
        send_request(OP_CLEAR, 10'd0, 10'd0);
        run_random_burst(290, 69, 0, 1'b1);
    endtask

    task automatic test_random_receiver_stall();
        settle_and_write(CFG_PACK_ENABLE, 1'b0);
        run_random_burst(290, 0, 69, 1'b0);
    endtask

    task automatic test_random_both_idle();
        settle_and_write(CFG_LEVEL_MODE, 1'b0);
        settle_and_write(CFG_PACK_ENABLE, 1'b1);
        send_request(OP_CLEAR, 10'd0, 10'd0);
        run_random_burst(290, 22, 22, 1'b0);
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= '0;
        cfg_wdata          <= '0;
        req_bus.valid      <= 1'b0;
        req_bus.opcode     <= OP_ALLOC;
        req_bus.req_width  <= '0;
        req_bus.req_height <= '0;
        model_enable     = 1'b1;
        model_level_mode = 1'b0;
        load_level_profile();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_height_and_width_limits();
        test_alignment();
        test_disabled();
        test_level_profile();
        test_random_no_idle();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();

        stop_requests();
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_placements.size() != 0)
        begin
            $error("%0d responses never arrived", expected_placements.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("texture_vram_row_packer_core verification clean");
        else
            $display("texture_vram_row_packer_core verification failed");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/tvrp_pkg.sv
rtl/core/tvrp_if.sv
rtl/core/texture_vram_row_packer_core.sv
dv/tb_texture_vram_row_packer_core.sv
